// File: rtl/core/base64_decoder_defines.svh
// Assertion helpers shared by the RTL. All sample on clk and are off during rst.
`ifndef BASE64_DECODER_DEFINES_SVH
`define BASE64_DECODER_DEFINES_SVH

// Same-cycle implication.
`define B64_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/b64_pkg.sv
package b64_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
  localparam logic [7:0] UC_A     = 8'h41;  // 'A'
  localparam logic [7:0] UC_Z     = 8'h5A;
  localparam logic [7:0] LC_A     = 8'h61;  // 'a'
  localparam logic [7:0] LC_Z     = 8'h7A;
  localparam logic [7:0] DIG_0    = 8'h30;  // '0'
  localparam logic [7:0] DIG_9    = 8'h39;
  localparam logic [7:0] PLUS_CHR = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHR = 8'h2F; // '/'

  // One decoded group: 24-bit word and number of bytes to emit (1..3).
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
  } grp_t;

  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= UC_A && c <= UC_Z) begin
      v = c - UC_A;
    end else if (c >= LC_A && c <= LC_Z) begin
      v = c - LC_A + 8'd26;
    end else if (c >= DIG_0 && c <= DIG_9) begin
      v = c - DIG_0 + 8'd52;
    end else if (c == PLUS_CHR) begin
      v = 8'd62;
    end else if (c == SLASH_CHR) begin
      v = 8'd63;
    end
    return v[5:0];
  endfunction

endpackage

// File: rtl/core/base64_decoder.sv
// Streaming Base64 decoder (standard alphabet). Characters enter one per
// transaction on the s_ side; every fourth character closes a group and
// yields 3 minus the number of '=' pads in it (none for three or more pads)
// bytes on the m_ side, most significant first, with m_tlast on the group's
// final byte. Characters outside the alphabet decode as zero. Input runs at
// one character per cycle while s_tready is high; while m_tready is high the
// output side emits one byte per cycle, so a full group of four characters
// drains faster than the next one arrives and the stream never backs up on its
// own. The closing character writes the queue; the byte loader then takes the
// group into its current-group register and from there loads the output
// register, after which m_tvalid rises and the first byte can be accepted.
// The queue between the character side and the byte side absorbs QUEUE_DEPTH
// groups of downstream stall before s_tready drops on a closing character.
module base64_decoder
  import b64_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2  // groups held between front and back, 2 or more
) (
  input  logic       clk,
  input  logic       rst,
  // character input
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  // byte output
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // group_end
);

  // front -> queue
  logic q_push;
  logic q_full;
  grp_t q_wr;

  // queue -> back
  logic q_pop;
  logic q_valid;
  grp_t q_rd;

  // Front: sextet lookup, packs three sextets, counts pads, and on the
  // closing character queues the word plus byte count if any byte is due.
  b64_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_char  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr)
  );

  b64_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_data  (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  // Back: walks the bytes of one group into the output register, popping
  // the next group in the same cycle its last byte is loaded.
  b64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_rd),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// File: rtl/core/b64_front.sv
module b64_front
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       q_full,
  output logic       q_push,
  output grp_t       q_data
);

  logic [1:0]  pos;
  logic [17:0] acc;
  logic [1:0]  pads;

  logic [5:0] sext;
  logic       is_pad;
  logic [2:0] pads_total;
  logic [1:0] nbytes;
  logic       take;

  assign sext       = sextet_of(in_char);
  assign is_pad     = (in_char == PAD_CHAR);
  assign pads_total = {1'b0, pads} + {2'b00, is_pad};
  assign nbytes     = (pads_total >= 3'd3) ? 2'd0 : 2'(3'd3 - pads_total);

  // only the closing character of a group needs queue space
  assign in_ready = (pos != 2'd3) || !q_full;
  assign take     = in_valid && in_ready;

  assign q_push        = take && (pos == 2'd3) && (nbytes != 2'd0);
  assign q_data.word   = {acc, sext};
  assign q_data.nbytes = nbytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= 2'd0;
      acc  <= '0;
      pads <= 2'd0;
    end else if (take) begin
      if (pos == 2'd3) begin
        pos  <= 2'd0;
        acc  <= '0;
        pads <= 2'd0;
      end else begin
        pos  <= pos + 2'd1;
        acc  <= {acc[11:0], sext};
        pads <= pads_total[1:0];
      end
    end
  end

endmodule

// File: rtl/core/b64_fifo.sv
`include "base64_decoder_defines.svh"

module b64_fifo
  import b64_pkg::*;
#(
  parameter int DEPTH = 2  // 2 or more
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  grp_t wr_data,
  output logic full,
  input  logic pop,
  output logic rd_valid,
  output grp_t rd_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  grp_t             mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `B64_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")
  `B64_ASSERT_NOW(a_no_underflow, pop, rd_valid, "pop from empty queue")
  `B64_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count did not rise")
  `B64_ASSERT_NOW(a_entry_nonempty, rd_valid, rd_data.nbytes != 2'd0, "queued group emits no byte")

endmodule

// File: rtl/core/b64_back.sv
module b64_back
  import b64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  grp_t       q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic        cur_valid;
  logic [23:0] cur_word;
  logic [1:0]  cur_n;
  logic [1:0]  cur_k;

  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = !out_valid || out_ready;
  assign is_last = ((cur_k + 2'd1) == cur_n);
  assign q_pop   = q_valid && (!cur_valid || (load && is_last));

  always_comb begin
    case (cur_k)
      2'd0:    sel_byte = cur_word[23:16];
      2'd1:    sel_byte = cur_word[15:8];
      default: sel_byte = cur_word[7:0];
    endcase
  end

  // cur_k is back at zero whenever cur_valid is low, so a pop starts at byte 0
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_k     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= cur_valid;
      end
      if (load && cur_valid) begin
        out_byte <= sel_byte;
        out_last <= is_last;
        cur_k    <= is_last ? 2'd0 : cur_k + 2'd1;
        if (is_last && !q_pop) begin
          cur_valid <= 1'b0;
        end
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        cur_word  <= q_data.word;
        cur_n     <= q_data.nbytes;
      end
    end
  end

endmodule
